// File: rtl/http2_frame_deframer_defines.svh
// assertion macros for the http2 frame deframer
// included by the rtl files that carry concurrent checks
`ifndef HTTP2_FRAME_DEFRAMER_DEFINES_SVH
`define HTTP2_FRAME_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define H2FD_ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("h2fd check failed");
`define H2FD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("h2fd check failed");
`else
`define H2FD_ASSERT_ALWAYS(lbl, clk, rst, prop)
`define H2FD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/h2fd_pkg.sv
// types, codes and header check functions for the http2 frame deframer
// no dependencies
`default_nettype none
package h2fd_pkg;

  typedef enum logic [2:0] {
    PH_HDR, PH_PADLEN, PH_PRIO, PH_WORD, PH_SETTING, PH_DATA, PH_PAD, PH_SKIP
  } phase_t;

  localparam logic [2:0] KIND_HEADER    = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD   = 3'd1;
  localparam logic [2:0] KIND_PRIORITY  = 3'd2;
  localparam logic [2:0] KIND_SETTING   = 3'd3;
  localparam logic [2:0] KIND_WORD      = 3'd4;
  localparam logic [2:0] KIND_ERROR     = 3'd5;
  localparam logic [2:0] KIND_FRAME_END = 3'd6;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_PROTOCOL = 2'd1;
  localparam logic [1:0] ERR_SIZE     = 2'd2;

  localparam logic [7:0] T_DATA          = 8'd0;
  localparam logic [7:0] T_HEADERS       = 8'd1;
  localparam logic [7:0] T_PRIORITY      = 8'd2;
  localparam logic [7:0] T_RESET_STREAM  = 8'd3;
  localparam logic [7:0] T_SETTINGS      = 8'd4;
  localparam logic [7:0] T_PUSH_PROMISE  = 8'd5;
  localparam logic [7:0] T_PING          = 8'd6;
  localparam logic [7:0] T_GOAWAY        = 8'd7;
  localparam logic [7:0] T_WINDOW_UPDATE = 8'd8;
  localparam logic [7:0] T_CONTINUATION  = 8'd9;

  localparam int FLAG_ACK_BIT      = 0;
  localparam int FLAG_PADDED_BIT   = 3;
  localparam int FLAG_PRIORITY_BIT = 5;

  localparam logic [3:0] HDR_BYTES_LAST = 4'd8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [30:0] sid;
    logic [23:0] frame_length;
    logic [31:0] word_value;
    logic [15:0] setting_id;
    logic [7:0]  data_byte;
    logic        dep_exclusive;
    logic [8:0]  dep_weight;
    logic [1:0]  error_kind;
    logic        frame_last;
  } result_t;

  function automatic logic can_pad(input logic [7:0] t);
    can_pad = (t == T_DATA) || (t == T_HEADERS) || (t == T_PUSH_PROMISE);
  endfunction

  function automatic logic [1:0] header_check(input logic [7:0] t, input logic [7:0] f,
                                              input logic sid_zero, input logic [23:0] len,
                                              input logic len_m6_zero);
    logic need_sid;
    logic zero_sid;
    logic [1:0] e;
    need_sid = (t <= T_RESET_STREAM) || (t == T_PUSH_PROMISE) || (t == T_CONTINUATION);
    zero_sid = (t == T_SETTINGS) || (t == T_PING) || (t == T_GOAWAY);
    e = ERR_NONE;
    if ((need_sid && sid_zero) || (zero_sid && !sid_zero)) begin
      e = ERR_PROTOCOL;
    end else if ((t == T_PRIORITY && len != 24'd5) ||
                 ((t == T_RESET_STREAM || t == T_WINDOW_UPDATE) && len != 24'd4) ||
                 (t == T_SETTINGS && ((f[FLAG_ACK_BIT] && len != 24'd0) || !len_m6_zero)) ||
                 (t == T_PING && len != 24'd8) ||
                 (t == T_GOAWAY && len < 24'd8)) begin
      e = ERR_SIZE;
    end else if (can_pad(t) && f[FLAG_PADDED_BIT]) begin
      if (len == 24'd0) e = ERR_PROTOCOL;
    end else if ((t == T_HEADERS && f[FLAG_PRIORITY_BIT] && len < 24'd5) ||
                 (t == T_PUSH_PROMISE && len < 24'd4)) begin
      e = ERR_SIZE;
    end
    header_check = e;
  endfunction

  // phase after the frame header or pad length byte
  function automatic phase_t body_phase(input logic [7:0] t, input logic [7:0] f,
                                        input logic [23:0] rem, input logic [7:0] pad);
    phase_t p;
    case (t)
      T_DATA, T_PING, T_CONTINUATION: p = PH_DATA;
      T_HEADERS: p = f[FLAG_PRIORITY_BIT] ? PH_PRIO : PH_DATA;
      T_PRIORITY: p = PH_PRIO;
      T_RESET_STREAM, T_PUSH_PROMISE, T_GOAWAY, T_WINDOW_UPDATE: p = PH_WORD;
      T_SETTINGS: p = PH_SETTING;
      default: p = PH_SKIP;
    endcase
    if (p == PH_DATA && rem <= {16'd0, pad}) p = (rem != 24'd0) ? PH_PAD : PH_HDR;
    body_phase = p;
  endfunction

  function automatic phase_t field_phase(input logic [23:0] rem, input logic [7:0] pad);
    if (rem == 24'd0) field_phase = PH_HDR;
    else if (rem > {16'd0, pad}) field_phase = PH_DATA;
    else field_phase = PH_PAD;
  endfunction

endpackage
`default_nettype wire

// File: rtl/h2fd_byte_if.sv
// byte stream channel of the http2 frame deframer
// standalone, no dependencies
`default_nettype none
interface h2fd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/h2fd_result_if.sv
// result channel of the http2 frame deframer
// standalone, no dependencies
`default_nettype none
interface h2fd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  frame_type;
  logic [7:0]  frame_flags;
  logic [30:0] sid;
  logic [23:0] frame_length;
  logic [31:0] word_value;
  logic [15:0] setting_id;
  logic [7:0]  data_byte;
  logic        dep_exclusive;
  logic [8:0]  dep_weight;
  logic [1:0]  error_kind;
  logic        frame_last;
  modport source (output valid, output kind, output frame_type, output frame_flags,
                  output sid, output frame_length, output word_value,
                  output setting_id, output data_byte, output dep_exclusive,
                  output dep_weight, output error_kind, output frame_last, input ready);
  modport sink (input valid, input kind, input frame_type, input frame_flags,
                input sid, input frame_length, input word_value,
                input setting_id, input data_byte, input dep_exclusive,
                input dep_weight, input error_kind, input frame_last, output ready);
endinterface
`default_nettype wire

// File: rtl/h2fd_parser.sv
// frame parser state and per-byte decode of the http2 frame deframer
// depends on h2fd_pkg and the assertion macro header
`default_nettype none
`include "http2_frame_deframer_defines.svh"
module h2fd_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        in_byte,
  output logic                   res_valid,
  output h2fd_pkg::result_t      res
);
  import h2fd_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  hdr_count, hdr_count_next;
  logic [63:0] hdr_store, hdr_store_next;
  logic [23:0] frame_len, frame_len_next;
  logic [23:0] rem_len, rem_len_next;
  logic [7:0]  pad_rem, pad_rem_next;
  logic [31:0] word_shift, word_shift_next;
  logic [2:0]  field_count, field_count_next;
  logic [15:0] pend_setting, pend_setting_next;
  logic [2:0]  len_mod6, len_mod6_next;

  // running length mod 6 over the three length bytes
  logic [8:0]  m6_x;
  logic [15:0] m6_prod;
  logic [6:0]  m6_q;
  logic [9:0]  m6_r;
  logic [9:0]  m6_fix;

  always_comb begin
    m6_x    = {4'd0, ((hdr_count == 4'd0) ? 3'd0 : len_mod6), 2'b00} + {1'b0, in_byte};
    m6_prod = {7'd0, m6_x} * 16'd85;
    m6_q    = m6_prod[15:9];
    m6_r    = {1'b0, m6_x} - ({3'd0, m6_q} * 10'd6);
    m6_fix  = (m6_r >= 10'd6) ? (m6_r - 10'd6) : m6_r;
  end

  always_comb begin
    logic [23:0] rem_dec;
    logic        is_last;
    logic [7:0]  t;
    logic [7:0]  f;
    logic [31:0] ws_sh;
    logic [23:0] hdr_len;
    logic [7:0]  hdr_t;
    logic [7:0]  hdr_f;
    logic [30:0] hdr_sid;
    logic [1:0]  hdr_err;
    logic [1:0]  pl_err;
    logic [23:0] region;
    logic [31:0] v;
    logic [2:0]  r_kind;
    logic [31:0] r_word;
    logic [15:0] r_sid16;
    logic [7:0]  r_data;
    logic        r_excl;
    logic [8:0]  r_weight;
    logic [1:0]  r_err;
    logic        r_last;

    phase_next        = phase;
    hdr_count_next    = hdr_count;
    hdr_store_next    = hdr_store;
    frame_len_next    = frame_len;
    rem_len_next      = rem_len;
    pad_rem_next      = pad_rem;
    word_shift_next   = word_shift;
    field_count_next  = field_count;
    pend_setting_next = pend_setting;
    len_mod6_next     = len_mod6;

    res_valid = 1'b0;
    r_kind    = KIND_HEADER;
    r_word    = '0;
    r_sid16   = '0;
    r_data    = '0;
    r_excl    = 1'b0;
    r_weight  = '0;
    r_err     = ERR_NONE;
    r_last    = 1'b0;

    rem_dec = (rem_len != 24'd0) ? (rem_len - 24'd1) : rem_len;
    is_last = (rem_dec == 24'd0);
    t       = hdr_store[47:40];
    f       = hdr_store[39:32];
    ws_sh   = {word_shift[23:0], in_byte};
    hdr_len = hdr_store[63:40];
    hdr_t   = hdr_store[39:32];
    hdr_f   = hdr_store[31:24];
    hdr_sid = {hdr_store[22:0], in_byte};
    hdr_err = header_check(hdr_t, hdr_f, hdr_sid == 31'd0, hdr_len, len_mod6 == 3'd0);
    pl_err  = ERR_NONE;
    region  = rem_dec - {16'd0, in_byte};
    v       = ws_sh;

    if (phase == PH_HDR) begin
      if (hdr_count < HDR_BYTES_LAST) begin
        hdr_store_next = {hdr_store[55:0], in_byte};
        hdr_count_next = hdr_count + 4'd1;
        if (hdr_count < 4'd3) len_mod6_next = m6_fix[2:0];
      end else begin
        hdr_count_next    = '0;
        hdr_store_next    = {16'd0, hdr_t, hdr_f, 1'b0, hdr_sid};
        frame_len_next    = hdr_len;
        rem_len_next      = hdr_len;
        pad_rem_next      = '0;
        field_count_next  = '0;
        word_shift_next   = '0;
        pend_setting_next = '0;
        res_valid         = 1'b1;
        r_last            = (hdr_len == 24'd0);
        if (hdr_err != ERR_NONE) begin
          r_kind     = KIND_ERROR;
          r_err      = hdr_err;
          phase_next = r_last ? PH_HDR : PH_SKIP;
        end else if (r_last) begin
          phase_next = PH_HDR;
        end else if (can_pad(hdr_t) && hdr_f[FLAG_PADDED_BIT]) begin
          phase_next = PH_PADLEN;
        end else begin
          phase_next = body_phase(hdr_t, hdr_f, hdr_len, 8'd0);
        end
      end
    end else begin
      rem_len_next = rem_dec;
      r_last       = is_last;
      case (phase)
        PH_PADLEN: begin
          if ({16'd0, in_byte} > rem_dec) begin
            pl_err = ERR_PROTOCOL;
          end else if ((t == T_HEADERS && f[FLAG_PRIORITY_BIT] && region < 24'd5) ||
                       (t == T_PUSH_PROMISE && region < 24'd4)) begin
            pl_err = ERR_SIZE;
          end
          if (pl_err != ERR_NONE) begin
            res_valid  = 1'b1;
            r_kind     = KIND_ERROR;
            r_err      = pl_err;
            phase_next = PH_SKIP;
          end else begin
            pad_rem_next = in_byte;
            if (!is_last) begin
              field_count_next = '0;
              word_shift_next  = '0;
              phase_next       = body_phase(t, f, rem_dec, in_byte);
            end
          end
        end
        PH_PRIO: begin
          if (field_count < 3'd4) begin
            word_shift_next  = ws_sh;
            field_count_next = field_count + 3'd1;
          end else begin
            res_valid        = 1'b1;
            r_kind           = KIND_PRIORITY;
            r_word           = {1'b0, word_shift[30:0]};
            r_excl           = word_shift[31];
            r_weight         = {1'b0, in_byte} + 9'd1;
            field_count_next = '0;
            word_shift_next  = '0;
            phase_next       = field_phase(rem_dec, pad_rem);
          end
        end
        PH_WORD: begin
          word_shift_next = ws_sh;
          if (field_count[1:0] == 2'd3) begin
            // stream reset codes and the goaway error code keep bit 31
            if (!(t == T_RESET_STREAM || (t == T_GOAWAY && field_count == 3'd7))) v[31] = 1'b0;
            res_valid = 1'b1;
            r_kind    = KIND_WORD;
            r_word    = v;
            if (t == T_GOAWAY && field_count == 3'd3) begin
              word_shift_next  = '0;
              field_count_next = 3'd4;
            end else begin
              field_count_next = '0;
              word_shift_next  = '0;
              phase_next       = field_phase(rem_dec, pad_rem);
            end
          end else begin
            field_count_next = field_count + 3'd1;
          end
        end
        PH_SETTING: begin
          if (field_count < 3'd2) pend_setting_next = {pend_setting[7:0], in_byte};
          else word_shift_next = ws_sh;
          if (field_count >= 3'd5) begin
            res_valid         = 1'b1;
            r_kind            = KIND_SETTING;
            r_word            = word_shift_next;
            r_sid16           = pend_setting_next;
            field_count_next  = '0;
            word_shift_next   = '0;
            pend_setting_next = '0;
          end else begin
            field_count_next = field_count + 3'd1;
          end
        end
        PH_DATA: begin
          res_valid = 1'b1;
          r_kind    = KIND_PAYLOAD;
          r_data    = in_byte;
          if (rem_dec <= {16'd0, pad_rem}) phase_next = PH_PAD;
        end
        default: begin
        end
      endcase
      if (is_last) begin
        if (!res_valid) begin
          res_valid = 1'b1;
          r_kind    = KIND_FRAME_END;
        end
        phase_next        = PH_HDR;
        field_count_next  = '0;
        word_shift_next   = '0;
        pend_setting_next = '0;
        pad_rem_next      = '0;
      end
    end

    res.kind          = r_kind;
    res.frame_type    = hdr_store_next[47:40];
    res.frame_flags   = hdr_store_next[39:32];
    res.sid           = hdr_store_next[30:0];
    res.frame_length  = frame_len_next;
    res.word_value    = r_word;
    res.setting_id    = r_sid16;
    res.data_byte     = r_data;
    res.dep_exclusive = r_excl;
    res.dep_weight    = r_weight;
    res.error_kind    = r_err;
    res.frame_last    = r_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR;
      hdr_count    <= '0;
      hdr_store    <= '0;
      frame_len    <= '0;
      rem_len      <= '0;
      pad_rem      <= '0;
      word_shift   <= '0;
      field_count  <= '0;
      pend_setting <= '0;
      len_mod6     <= '0;
    end else if (take) begin
      phase        <= phase_next;
      hdr_count    <= hdr_count_next;
      hdr_store    <= hdr_store_next;
      frame_len    <= frame_len_next;
      rem_len      <= rem_len_next;
      pad_rem      <= pad_rem_next;
      word_shift   <= word_shift_next;
      field_count  <= field_count_next;
      pend_setting <= pend_setting_next;
      len_mod6     <= len_mod6_next;
    end
  end

  `H2FD_ASSERT_ALWAYS(a_hdr_count_range, clk, rst, hdr_count <= HDR_BYTES_LAST)
  `H2FD_ASSERT_IMPLIES(a_body_count_clear, clk, rst, phase != PH_HDR, hdr_count == 4'd0)
  `H2FD_ASSERT_IMPLIES(a_error_coded, clk, rst, res_valid && res.kind == KIND_ERROR, res.error_kind != ERR_NONE)

endmodule
`default_nettype wire

// File: rtl/h2fd_out_stage.sv
// output register of the http2 frame deframer, drives the result channel
// depends on h2fd_pkg, h2fd_result_if and the assertion macro header
`default_nettype none
`include "http2_frame_deframer_defines.svh"
module h2fd_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic              load_valid,
  input  wire h2fd_pkg::result_t res,
  output logic                   can_load,
  h2fd_result_if.source          result
);
  import h2fd_pkg::*;

  logic    valid;
  result_t held;

  // a held result frees the register in the cycle it is taken
  assign can_load = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load && load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load && load_valid) held <= res;
  end

  assign result.valid         = valid;
  assign result.kind          = held.kind;
  assign result.frame_type    = held.frame_type;
  assign result.frame_flags   = held.frame_flags;
  assign result.sid           = held.sid;
  assign result.frame_length  = held.frame_length;
  assign result.word_value    = held.word_value;
  assign result.setting_id    = held.setting_id;
  assign result.data_byte     = held.data_byte;
  assign result.dep_exclusive = held.dep_exclusive;
  assign result.dep_weight    = held.dep_weight;
  assign result.error_kind    = held.error_kind;
  assign result.frame_last    = held.frame_last;

  `H2FD_ASSERT_IMPLIES(a_frame_end_last, clk, rst, valid && held.kind == KIND_FRAME_END, held.frame_last)

endmodule
`default_nettype wire

// File: rtl/http2_frame_deframer.sv
// HTTP/2 frame deframer. Takes one byte of the frame stream per transaction on
// "stream" and gives at most one result per byte on "result": a header result
// (or an error) on the ninth header byte, then payload bytes, priority blocks,
// settings pairs and 32-bit fields, with frame_last set on the result of the
// last byte of each frame; padding and the body of unknown or failed frames
// give a single frame-end result. A byte is accepted every cycle while the
// result register is empty or being read; its result is registered in the single
// output register stage and appears in the cycle after acceptance.
// depends on h2fd_pkg, h2fd_byte_if, h2fd_result_if, h2fd_parser, h2fd_out_stage
`default_nettype none
module http2_frame_deframer (
  input  wire logic     clk,
  input  wire logic     rst,
  h2fd_byte_if.sink     stream,
  h2fd_result_if.source result
);
  import h2fd_pkg::*;

  logic    can_load;
  logic    take;
  logic    res_valid;
  result_t res;

  assign stream.ready = can_load;
  assign take         = stream.valid && can_load;

  h2fd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (stream.in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  h2fd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .load_valid (res_valid),
    .res        (res),
    .can_load   (can_load),
    .result     (result)
  );

endmodule
`default_nettype wire
